// ----- src/rbts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rbts_pkg;

  localparam int unsigned BUCKET_COUNT = 1024;
  localparam int unsigned BIDX_W       = $clog2(BUCKET_COUNT);

  localparam int unsigned TS_W   = 53;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned PX_W   = 48;
  localparam int unsigned QTY_W  = 48;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned VOL_W  = 56;
  localparam int unsigned WCNT_W = 42;
  localparam int unsigned WVOL_W = 63;
  localparam int unsigned PCHG_W = 49;
  localparam int unsigned SPAN_W = WIN_W + LEN_W;
  localparam int unsigned PSUM_W = PX_W + BIDX_W;
  localparam int unsigned DVD_W  = 64;
  localparam int unsigned DCNT_W = $clog2(DVD_W) + 1;

  localparam logic [1:0] OP_DEPTH = 2'd0;
  localparam logic [1:0] OP_TRADE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [TS_W-1:0]  start;
    logic [CNT_W-1:0] bid;
    logic [CNT_W-1:0] ask;
    logic             has_depth;
    logic [CNT_W-1:0] buy;
    logic [CNT_W-1:0] sell;
    logic [VOL_W-1:0] buy_vol;
    logic [VOL_W-1:0] sell_vol;
    logic [PX_W-1:0]  last_px;
    logic             has_trade;
  } bucket_t;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  function automatic logic [VOL_W-1:0] sat_vol(input logic [VOL_W-1:0] a,
                                               input logic [QTY_W-1:0] q);
    logic [VOL_W:0] s;
    s = {1'b0, a} + {{(VOL_W + 1 - QTY_W){1'b0}}, q};
    return s[VOL_W] ? '1 : s[VOL_W-1:0];
  endfunction

  function automatic logic [WCNT_W-1:0] sat_wcnt(input logic [WCNT_W-1:0] a,
                                                 input logic [CNT_W-1:0]  c);
    logic [WCNT_W:0] s;
    s = {1'b0, a} + {{(WCNT_W + 1 - CNT_W){1'b0}}, c};
    return s[WCNT_W] ? '1 : s[WCNT_W-1:0];
  endfunction

  function automatic logic [WVOL_W-1:0] sat_wvol(input logic [WVOL_W-1:0] a,
                                                 input logic [VOL_W-1:0]  v);
    logic [WVOL_W:0] s;
    s = {1'b0, a} + {{(WVOL_W + 1 - VOL_W){1'b0}}, v};
    return s[WVOL_W] ? '1 : s[WVOL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/rolling_bucket_trade_statistics.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel    Direction  Handshake                    Payload
// cfg        in         cfg_valid_i / cfg_ready_o    cfg_data_i: bucket length in us
// s_axis     in         s_axis_tvalid / tready       event or query request
// m_axis     out        m_axis_tvalid / tready       window statistics, one per query
//
// Event: a divide of the timestamp by the bucket length (64 quotient bits); when
// the side's time moves on, a second divide and a read and a write per skipped
// bucket (up to BUCKET_COUNT), then a read and a write for the bucket update.
// Query: a scan through the single store port, plus a divide for the average
// when any bucket with trades is in the window.
// After reset a clearing pass over all BUCKET_COUNT buckets zeroes the store; no
// request is taken meanwhile. A finished result waits in the output register;
// the next request is taken while it waits.
module rolling_bucket_trade_statistics (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // timestamp_us, is_ask, seller_initiated, price, quantity, window_buckets, pad
  input  wire logic [167:0] s_axis_tdata,
  // operation
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // bid_entries, ask_entries, buy_trades, sell_trades, buy_volume, sell_volume,
  // price_change, oldest_price, average_price, pad
  output logic [439:0]      m_axis_tdata
);

  localparam int unsigned TS_W   = rbts_pkg::TS_W;
  localparam int unsigned BIDX_W = rbts_pkg::BIDX_W;
  localparam int unsigned PX_W   = rbts_pkg::PX_W;

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_DIVTS   = 4'd2;
  localparam logic [3:0] ST_DIVOLD  = 4'd3;
  localparam logic [3:0] ST_WIPE_RD = 4'd4;
  localparam logic [3:0] ST_WIPE_WR = 4'd5;
  localparam logic [3:0] ST_UPD_RD  = 4'd6;
  localparam logic [3:0] ST_UPD_WR  = 4'd7;
  localparam logic [3:0] ST_QMUL    = 4'd8;
  localparam logic [3:0] ST_QSCAN   = 4'd9;
  localparam logic [3:0] ST_QDIV    = 4'd10;
  localparam logic [3:0] ST_OUT     = 4'd11;

  logic [3:0] state_q, state_d;

  logic [rbts_pkg::LEN_W-1:0] len_q, len;
  logic [1:0]                 op_q;
  logic [TS_W-1:0]            ts_q;
  logic                       ask_q, sell_q;
  logic [PX_W-1:0]            px_q;
  logic [rbts_pkg::QTY_W-1:0] qty_q;
  logic [rbts_pkg::WIN_W-1:0] win_q;
  logic [TS_W-1:0]            nd_q, nt_q, newest_side;
  logic [TS_W-1:0]            qts_q, bst_q, old_q, wst_q;
  logic [BIDX_W:0]            cnt_q;
  logic [BIDX_W-1:0]          idx_q;
  logic [rbts_pkg::SPAN_W-1:0] span_q;

  logic [BIDX_W:0]            addr_q;
  logic                       rv_q;
  logic [rbts_pkg::WCNT_W-1:0] bid_q, ask_acc_q, buy_q, sell_acc_q;
  logic [rbts_pkg::WVOL_W-1:0] bvol_q, svol_q;
  logic [rbts_pkg::PSUM_W-1:0] psum_q;
  logic [BIDX_W:0]            pcnt_q;
  logic                       have_cur_q, have_cut_q;
  logic [TS_W-1:0]            cur_t_q, cut_t_q;
  logic [PX_W-1:0]            cur_p_q, cut_p_q, avg_q;

  logic                       out_valid_q;
  logic [439:0]               out_q;

  logic                       in_acc;
  logic [1:0]                 in_op;
  logic [TS_W-1:0]            in_ts;

  logic                          div_start, div_done;
  logic [rbts_pkg::DVD_W-1:0]    div_dvd, div_quo;
  logic [rbts_pkg::LEN_W-1:0]    div_dvs, div_rem;

  logic                       mem_rd, mem_wr;
  logic [BIDX_W-1:0]          mem_addr;
  rbts_pkg::bucket_t          mem_wdata, mem_rdata;

  logic [TS_W-1:0]            nb;
  logic [BIDX_W:0]            ncap;
  logic                       scan_end;
  logic [TS_W:0]              stsp;
  logic                       dep_hit, tr_ok, win_hit, cut_ok, cur_upd, cut_upd;
  logic [rbts_pkg::PCHG_W-1:0] pchg;

  // a zero bucket length acts as one
  assign len         = (len_q == '0) ? rbts_pkg::LEN_W'(1) : len_q;
  assign in_op       = s_axis_tuser;
  assign in_ts       = s_axis_tdata[52:0];
  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign newest_side = (op_q == rbts_pkg::OP_TRADE) ? nt_q : nd_q;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);

  // skipped bucket count, capped at one full turn of the ring
  assign nb   = qts_q - div_quo[TS_W-1:0];
  assign ncap = (nb > TS_W'(rbts_pkg::BUCKET_COUNT)) ?
                (BIDX_W + 1)'(rbts_pkg::BUCKET_COUNT) : nb[BIDX_W:0];

  assign scan_end = addr_q[BIDX_W] && !rv_q;

  // per-bucket window tests during the scan
  always_comb begin
    stsp    = {1'b0, mem_rdata.start} + {{(TS_W + 1 - rbts_pkg::SPAN_W){1'b0}}, span_q};
    dep_hit = rv_q && (nd_q != '0) && mem_rdata.has_depth && (stsp >= {1'b0, nd_q});
    tr_ok   = rv_q && (nt_q != '0) && mem_rdata.has_trade;
    win_hit = tr_ok && (stsp >= {1'b0, nt_q});
    cut_ok  = tr_ok && (stsp <= {1'b0, nt_q});
    cur_upd = tr_ok && (!have_cur_q || (mem_rdata.start > cur_t_q));
    cut_upd = cut_ok && (!have_cut_q || (mem_rdata.start > cut_t_q));
    pchg    = (have_cur_q && have_cut_q) ? ({1'b0, cur_p_q} - {1'b0, cut_p_q}) : '0;
  end

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {{(rbts_pkg::DVD_W - TS_W){1'b0}}, in_ts};
    div_dvs   = len;
    unique case (state_q)
      ST_IDLE: begin
        div_start = in_acc && ((in_op == rbts_pkg::OP_DEPTH) ||
                               (in_op == rbts_pkg::OP_TRADE));
      end
      ST_DIVTS: begin
        div_start = div_done && (ts_q > newest_side);
        div_dvd   = {{(rbts_pkg::DVD_W - TS_W){1'b0}}, newest_side};
      end
      ST_QSCAN: begin
        div_start = scan_end && (pcnt_q != '0);
        div_dvd   = {{(rbts_pkg::DVD_W - rbts_pkg::PSUM_W){1'b0}}, psum_q};
        div_dvs   = {{(rbts_pkg::LEN_W - BIDX_W - 1){1'b0}}, pcnt_q};
      end
      default: ;
    endcase
  end

  // store port
  always_comb begin
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = mem_rdata;
    unique case (state_q)
      ST_CLR: begin
        mem_wr    = 1'b1;
        mem_wdata = '0;
      end
      ST_WIPE_RD: mem_rd = 1'b1;
      ST_WIPE_WR: begin
        mem_wr          = 1'b1;
        mem_wdata.start = wst_q;
        if (op_q == rbts_pkg::OP_TRADE) begin
          mem_wdata.buy       = '0;
          mem_wdata.sell      = '0;
          mem_wdata.buy_vol   = '0;
          mem_wdata.sell_vol  = '0;
          mem_wdata.last_px   = '0;
          mem_wdata.has_trade = 1'b0;
        end else begin
          mem_wdata.bid       = '0;
          mem_wdata.ask       = '0;
          mem_wdata.has_depth = 1'b0;
        end
      end
      ST_UPD_RD: begin
        mem_rd   = 1'b1;
        mem_addr = qts_q[BIDX_W-1:0];
      end
      ST_UPD_WR: begin
        mem_wr          = 1'b1;
        mem_addr        = qts_q[BIDX_W-1:0];
        mem_wdata.start = bst_q;
        if (op_q == rbts_pkg::OP_TRADE) begin
          mem_wdata.has_trade = 1'b1;
          mem_wdata.last_px   = px_q;
          if (sell_q) begin
            mem_wdata.sell     = rbts_pkg::sat_cnt(mem_rdata.sell);
            mem_wdata.sell_vol = rbts_pkg::sat_vol(mem_rdata.sell_vol, qty_q);
          end else begin
            mem_wdata.buy     = rbts_pkg::sat_cnt(mem_rdata.buy);
            mem_wdata.buy_vol = rbts_pkg::sat_vol(mem_rdata.buy_vol, qty_q);
          end
        end else begin
          mem_wdata.has_depth = 1'b1;
          if (ask_q) begin
            mem_wdata.ask = rbts_pkg::sat_cnt(mem_rdata.ask);
          end else begin
            mem_wdata.bid = rbts_pkg::sat_cnt(mem_rdata.bid);
          end
        end
      end
      ST_QSCAN: begin
        mem_rd   = !addr_q[BIDX_W];
        mem_addr = addr_q[BIDX_W-1:0];
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR: if (idx_q == BIDX_W'(rbts_pkg::BUCKET_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == rbts_pkg::OP_QUERY) begin
            state_d = ST_QMUL;
          end else if (in_op == rbts_pkg::OP_DEPTH || in_op == rbts_pkg::OP_TRADE) begin
            state_d = ST_DIVTS;
          end
        end
      end
      ST_DIVTS: if (div_done) state_d = (ts_q > newest_side) ? ST_DIVOLD : ST_UPD_RD;
      ST_DIVOLD: if (div_done) state_d = (ncap == '0) ? ST_UPD_RD : ST_WIPE_RD;
      ST_WIPE_RD: state_d = ST_WIPE_WR;
      ST_WIPE_WR: state_d = (cnt_q == (BIDX_W + 1)'(1)) ? ST_UPD_RD : ST_WIPE_RD;
      ST_UPD_RD: state_d = ST_UPD_WR;
      ST_UPD_WR: state_d = ST_IDLE;
      ST_QMUL: state_d = ST_QSCAN;
      ST_QSCAN: if (scan_end) state_d = (pcnt_q != '0) ? ST_QDIV : ST_OUT;
      ST_QDIV: if (div_done) state_d = ST_OUT;
      ST_OUT: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      idx_q       <= '0;
      len_q       <= 32'd1000000;
      nd_q        <= '0;
      nt_q        <= '0;
      cnt_q       <= '0;
      addr_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        len_q <= cfg_data_i;
      end
      // load a new result once the output register is free, else hold it until taken
      if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLR: idx_q <= idx_q + 1'b1;
        ST_DIVTS: begin
          if (div_done && (ts_q > newest_side)) begin
            if (op_q == rbts_pkg::OP_TRADE) begin
              nt_q <= ts_q;
            end else begin
              nd_q <= ts_q;
            end
          end
        end
        ST_DIVOLD: begin
          if (div_done) begin
            cnt_q <= ncap;
            idx_q <= div_quo[BIDX_W-1:0] + 1'b1;
          end
        end
        ST_WIPE_WR: begin
          cnt_q <= cnt_q - 1'b1;
          idx_q <= idx_q + 1'b1;
        end
        ST_QMUL: begin
          addr_q <= '0;
          rv_q   <= 1'b0;
        end
        ST_QSCAN: begin
          rv_q <= mem_rd;
          if (mem_rd) begin
            addr_q <= addr_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= in_op;
      ts_q   <= in_ts;
      ask_q  <= s_axis_tdata[53];
      sell_q <= s_axis_tdata[54];
      px_q   <= s_axis_tdata[102:55];
      qty_q  <= s_axis_tdata[150:103];
      win_q  <= s_axis_tdata[166:151];
    end
    unique case (state_q)
      ST_DIVTS: begin
        if (div_done) begin
          qts_q <= div_quo[TS_W-1:0];
          bst_q <= ts_q - {{(TS_W - rbts_pkg::LEN_W){1'b0}}, div_rem};
          old_q <= newest_side;
        end
      end
      ST_DIVOLD: begin
        if (div_done) begin
          wst_q <= old_q - {{(TS_W - rbts_pkg::LEN_W){1'b0}}, div_rem}
                   + {{(TS_W - rbts_pkg::LEN_W){1'b0}}, len};
        end
      end
      ST_WIPE_WR: wst_q <= wst_q + {{(TS_W - rbts_pkg::LEN_W){1'b0}}, len};
      ST_QMUL: begin
        span_q     <= win_q * len;
        bid_q      <= '0;
        ask_acc_q  <= '0;
        buy_q      <= '0;
        sell_acc_q <= '0;
        bvol_q     <= '0;
        svol_q     <= '0;
        psum_q     <= '0;
        pcnt_q     <= '0;
        have_cur_q <= 1'b0;
        have_cut_q <= 1'b0;
        cur_t_q    <= '0;
        cut_t_q    <= '0;
        cur_p_q    <= '0;
        cut_p_q    <= '0;
      end
      ST_QSCAN: begin
        if (dep_hit) begin
          bid_q     <= rbts_pkg::sat_wcnt(bid_q, mem_rdata.bid);
          ask_acc_q <= rbts_pkg::sat_wcnt(ask_acc_q, mem_rdata.ask);
        end
        if (win_hit) begin
          buy_q      <= rbts_pkg::sat_wcnt(buy_q, mem_rdata.buy);
          sell_acc_q <= rbts_pkg::sat_wcnt(sell_acc_q, mem_rdata.sell);
          bvol_q     <= rbts_pkg::sat_wvol(bvol_q, mem_rdata.buy_vol);
          svol_q     <= rbts_pkg::sat_wvol(svol_q, mem_rdata.sell_vol);
          psum_q     <= psum_q + {{BIDX_W{1'b0}}, mem_rdata.last_px};
          pcnt_q     <= pcnt_q + 1'b1;
        end
        if (cur_upd) begin
          have_cur_q <= 1'b1;
          cur_t_q    <= mem_rdata.start;
          cur_p_q    <= mem_rdata.last_px;
        end
        if (cut_upd) begin
          have_cut_q <= 1'b1;
          cut_t_q    <= mem_rdata.start;
          cut_p_q    <= mem_rdata.last_px;
        end
        if (scan_end) begin
          avg_q <= '0;
        end
      end
      ST_QDIV: if (div_done) avg_q <= div_quo[PX_W-1:0];
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_q <= {1'b0, avg_q, cut_p_q, pchg, svol_q, bvol_q,
                    sell_acc_q, buy_q, ask_acc_q, bid_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  rbts_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  rbts_store u_store (
    .clk_i   (clk_i),
    .rd_en_i (mem_rd),
    .wr_en_i (mem_wr),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTHESIS
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !s_axis_tready)
    else $error("request taken during clearing pass");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output step");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVTS || state_q == ST_DIVOLD || state_q == ST_QDIV))
    else $error("divider finished with no owner");

  a_wipe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (BIDX_W + 1)'(rbts_pkg::BUCKET_COUNT))
    else $error("wipe count beyond ring depth");
`endif

endmodule
`default_nettype wire

// ----- src/rbts_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbts_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rbts_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [rbts_pkg::LEN_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [rbts_pkg::DVD_W-1:0]  quotient_o,
  output logic      [rbts_pkg::LEN_W-1:0]  remainder_o
);

  logic [rbts_pkg::DVD_W-1:0]  quo_q;
  logic [rbts_pkg::LEN_W-1:0]  rem_q;
  logic [rbts_pkg::LEN_W-1:0]  dvs_q;
  logic [rbts_pkg::DCNT_W-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [rbts_pkg::LEN_W:0]    trial;
  logic [rbts_pkg::LEN_W:0]    diff;
  logic                        ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, quo_q[rbts_pkg::DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rbts_pkg::DCNT_W'(rbts_pkg::DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rbts_pkg::DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[rbts_pkg::LEN_W-1:0] : trial[rbts_pkg::LEN_W-1:0];
      quo_q <= {quo_q[rbts_pkg::DVD_W-2:0], ge};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

// ----- src/rbts_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbts_store (
  input  wire logic                         clk_i,
  input  wire logic                         rd_en_i,
  input  wire logic                         wr_en_i,
  input  wire logic [rbts_pkg::BIDX_W-1:0]  addr_i,
  input  wire rbts_pkg::bucket_t            wdata_i,
  output rbts_pkg::bucket_t                 rdata_o
);

  rbts_pkg::bucket_t mem [rbts_pkg::BUCKET_COUNT];
  rbts_pkg::bucket_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
